// ===== src/dda_line_rasterizer_assert.svh =====
// assertion macros used by the rasterizer back end
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// clocked check, off while reset is asserted
`define DDA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define DDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dda_pkg.sv =====
package dda_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned EDGE_W  = 2;
  localparam int unsigned COLOR_W = 2;

  // command queue between front and back, depth must be a power of two
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_CYAN   = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [EDGE_W-1:0]  edge_req;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               valid_res;
  } res_item_t;

  typedef struct packed {
    logic               is_step;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic               x_neg;
    logic               y_neg;
    logic [COORD_W-1:0] len;
    logic [COLOR_W-1:0] color;
  } cmd_t;

endpackage

// ===== src/dda_front.sv =====
module dda_front import dda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t                 cmd_in;
  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;
  logic                 push_ok, pop_ok;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]   adx, ady;

  // classify the item and precompute deltas for the back end
  always_comb begin
    dx  = $signed({1'b0, in_data_i.x_end}) - $signed({1'b0, in_data_i.x_start});
    dy  = $signed({1'b0, in_data_i.y_end}) - $signed({1'b0, in_data_i.y_start});
    adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

    cmd_in.is_step = (in_data_i.mode == MODE_STEP);
    cmd_in.x_start = in_data_i.x_start;
    cmd_in.y_start = in_data_i.y_start;
    cmd_in.adx     = adx;
    cmd_in.ady     = ady;
    cmd_in.x_neg   = dx[COORD_W];
    cmd_in.y_neg   = dy[COORD_W];
    cmd_in.len     = (adx < ady) ? ady : adx;
    // edge index 2 and up all map to cyan
    cmd_in.color   = in_data_i.edge_req[1] ? COLOR_CYAN : in_data_i.edge_req;
  end

  assign full        = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_ok) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_ok)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_ok && !pop_ok)      count_q <= count_q + 1'b1;
      else if (!push_ok && pop_ok) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[wr_ptr_q] <= cmd_in;
  end

endmodule

// ===== src/dda_div.sv =====
module dda_div import dda_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] mag_i,
  input  logic [COORD_W-1:0] den_i,
  output logic               busy_o,
  output logic [FRAC_BITS:0] quot_o
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NW = COORD_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [NW-1:0]      num;
  logic [COORD_W:0]   rem_q, trial;
  logic [QW-1:0]      low_q, quot_q;
  logic [COORD_W-1:0] den_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, fits;

  // rounded numerator: |d| * 2^F + len/2; the quotient never exceeds 2^F
  assign num   = {mag_i, {FRAC_BITS{1'b0}}} + NW'(den_i >> 1);
  assign trial = {rem_q[COORD_W-1:0], low_q[QW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CW'(1));
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, num[NW-1:QW]};
      low_q  <= num[QW-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (trial - {1'b0, den_q}) : trial;
      low_q  <= {low_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== src/dda_back.sv =====
`include "dda_line_rasterizer_assert.svh"

module dda_back import dda_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop,
  output logic      empty,
  output res_item_t res_data_o
);

  localparam int unsigned AW = COORD_W + FRAC_BITS + 2;
  localparam int unsigned SW = FRAC_BITS + 2;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;
  logic signed [AW-1:0] x_acc_q, x_acc_d, y_acc_q, y_acc_d, x_sum, y_sum;
  logic signed [SW-1:0] x_step_q, x_step_d, y_step_q, y_step_d;
  logic [COORD_W-1:0]   steps_left_q, steps_left_d;
  logic [COLOR_W-1:0]   color_q, color_d;
  logic                 active_q, active_d;
  logic                 x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic                 out_valid_q, out_load, out_free;
  res_item_t            res_q, res_d;
  logic                 div_start, x_busy, y_busy;
  logic [FRAC_BITS:0]   x_quot, y_quot;

  function automatic logic [COORD_W-1:0] round_pix(logic signed [AW-1:0] a);
    logic [AW-1:0]           t;
    logic [AW-FRAC_BITS-1:0] r;
    t = a + HALF;
    r = t[AW-1:FRAC_BITS];
    if (a[AW-1]) return '0;
    else if (|r[AW-FRAC_BITS-1:COORD_W]) return '1;
    else return r[COORD_W-1:0];
  endfunction

  dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (cmd_i.adx),
    .den_i   (cmd_i.len),
    .busy_o  (x_busy),
    .quot_o  (x_quot)
  );

  dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (cmd_i.ady),
    .den_i   (cmd_i.len),
    .busy_o  (y_busy),
    .quot_o  (y_quot)
  );

  assign out_free = !out_valid_q || pop;
  assign x_sum = x_acc_q + {{(AW-SW){x_step_q[SW-1]}}, x_step_q};
  assign y_sum = y_acc_q + {{(AW-SW){y_step_q[SW-1]}}, y_step_q};

  always_comb begin
    state_d      = state_q;
    x_acc_d      = x_acc_q;
    y_acc_d      = y_acc_q;
    x_step_d     = x_step_q;
    y_step_d     = y_step_q;
    steps_left_d = steps_left_q;
    color_d      = color_q;
    active_d     = active_q;
    x_neg_d      = x_neg_q;
    y_neg_d      = y_neg_q;
    res_d        = res_q;
    out_load     = 1'b0;
    cmd_pop_o    = 1'b0;
    div_start    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_step) begin
            out_load = 1'b1;
            if (!active_q || steps_left_q == '0) begin
              active_d = 1'b0;
              res_d    = '0;
            end else begin
              x_acc_d         = x_sum;
              y_acc_d         = y_sum;
              steps_left_d    = steps_left_q - 1'b1;
              active_d        = (steps_left_q != COORD_W'(1));
              res_d.pixel_x   = round_pix(x_sum);
              res_d.pixel_y   = round_pix(y_sum);
              res_d.color     = color_q;
              res_d.last      = (steps_left_q == COORD_W'(1));
              res_d.valid_res = 1'b1;
            end
          end else begin
            color_d = cmd_i.color;
            x_acc_d = {2'b00, cmd_i.x_start, {FRAC_BITS{1'b0}}};
            y_acc_d = {2'b00, cmd_i.y_start, {FRAC_BITS{1'b0}}};
            if (cmd_i.len == '0) begin
              // zero-length line: single pixel, nothing to divide
              x_step_d        = '0;
              y_step_d        = '0;
              steps_left_d    = '0;
              active_d        = 1'b0;
              out_load        = 1'b1;
              res_d.pixel_x   = cmd_i.x_start;
              res_d.pixel_y   = cmd_i.y_start;
              res_d.color     = cmd_i.color;
              res_d.last      = 1'b1;
              res_d.valid_res = 1'b1;
            end else begin
              steps_left_d = cmd_i.len;
              active_d     = 1'b1;
              x_neg_d      = cmd_i.x_neg;
              y_neg_d      = cmd_i.y_neg;
              div_start    = 1'b1;
              state_d      = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        // first pixel goes out once both increments are known and the output register is free
        if (!x_busy && !y_busy && out_free) begin
          x_step_d        = x_neg_q ? -{1'b0, x_quot} : {1'b0, x_quot};
          y_step_d        = y_neg_q ? -{1'b0, y_quot} : {1'b0, y_quot};
          out_load        = 1'b1;
          res_d.pixel_x   = x_acc_q[FRAC_BITS +: COORD_W];
          res_d.pixel_y   = y_acc_q[FRAC_BITS +: COORD_W];
          res_d.color     = color_q;
          res_d.last      = 1'b0;
          res_d.valid_res = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      x_acc_q      <= '0;
      y_acc_q      <= '0;
      x_step_q     <= '0;
      y_step_q     <= '0;
      steps_left_q <= '0;
      color_q      <= '0;
      active_q     <= 1'b0;
      x_neg_q      <= 1'b0;
      y_neg_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      x_acc_q      <= x_acc_d;
      y_acc_q      <= y_acc_d;
      x_step_q     <= x_step_d;
      y_step_q     <= y_step_d;
      steps_left_q <= steps_left_d;
      color_q      <= color_d;
      active_q     <= active_d;
      x_neg_q      <= x_neg_d;
      y_neg_q      <= y_neg_d;
      if (out_load)   out_valid_q <= 1'b1;
      else if (pop)   out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) res_q <= res_d;
  end

  assign empty      = !out_valid_q;
  assign res_data_o = res_q;

  `DDA_ASSERT(a_busy_in_div, clk_i, rst_ni, (x_busy || y_busy) |-> (state_q == ST_DIV), "divider running outside division state")
  `DDA_ASSERT(a_active_steps, clk_i, rst_ni, active_q |-> (steps_left_q != '0), "active line with no steps left")
  `DDA_ASSERT(a_last_ends, clk_i, rst_ni, (out_load && res_d.last) |=> !active_q, "line still active after last pixel")
  `DDA_ASSERT(a_no_overwrite, clk_i, rst_ni, (out_valid_q && !pop) |-> !out_load, "pending result overwritten")
  `DDA_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |=> empty, "result pending after a reset edge")

endmodule

// ===== src/dda_line_rasterizer.sv =====
// a step or a zero-length start passes through the command queue into the result register;
// a start of nonzero length launches the bit-serial increment dividers (one quotient bit
// per cycle, x and y in parallel) and shows its first pixel once both have finished and
// the result register is free; one step pixel per cycle while results are popped; a start
// holds the back end while dividing, as a two-entry command queue keeps accepting items
// reset: rst_ni asynchronous active low, empties both queues and leaves no line active
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  input  logic      pop,
  output logic      empty,
  output res_item_t res_data_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  dda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  dda_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .res_data_o  (res_data_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench import dda_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS = 16;
  localparam int COORD_TOP = (1 << COORD_W) - 1;

  // side index of a triangle edge, picks the line color
  localparam logic [EDGE_W-1:0] EDGE_RED    = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_YELLOW = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_CYAN   = 2'd2;
  localparam logic [EDGE_W-1:0] EDGE_SPARE  = 2'd3;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned RANDOM_END  = 830;
  localparam int unsigned DRAIN_WAIT  = 25;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      pop = 1'b0;
  logic      empty;
  res_item_t res_data;

  res_item_t   expected_pixels[$];
  res_item_t   next_pixel;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap_max = 9;
  int unsigned pop_gap_max = 9;
  int unsigned pop_hold_cycles = 0;

  // line state of the predictor
  longint            line_x_acc = 0;
  longint            line_y_acc = 0;
  longint            line_x_inc = 0;
  longint            line_y_inc = 0;
  longint            pixels_left = 0;
  logic [COLOR_W-1:0] line_color = COLOR_RED;
  bit                line_on = 1'b0;

  dda_line_rasterizer #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data),
    .pop       (pop),
    .empty     (empty),
    .res_data_o(res_data)
  );

  initial begin
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  // fixed-point increment, magnitude rounded to nearest with ties away from zero
  function automatic longint dda_increment(longint d, longint len);
    longint mag;
    longint q;
    mag = (d < 0 ? -d : d) << FRAC_BITS;
    q = (mag + len / 2) / len;
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic [COORD_W-1:0] round_coord(longint acc);
    longint half;
    longint r;
    half = longint'(1) << (FRAC_BITS - 1);
    if (acc >= 0) begin
      r = (acc + half) >>> FRAC_BITS;
    end else begin
      r = -((-acc + half) >>> FRAC_BITS);
    end
    if (r < 0) r = 0;
    if (r > COORD_TOP) r = COORD_TOP;
    return r[COORD_W-1:0];
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_TOP) return COORD_TOP;
    return v;
  endfunction

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic in_item_t start_item(int x0, int y0, int x1, int y1,
                                          logic [EDGE_W-1:0] side);
    in_item_t it;
    it.mode     = MODE_START;
    it.x_start  = x0[COORD_W-1:0];
    it.y_start  = y0[COORD_W-1:0];
    it.x_end    = x1[COORD_W-1:0];
    it.y_end    = y1[COORD_W-1:0];
    it.edge_req = side;
    return it;
  endfunction

  // coordinates of a step are ignored, so fill them with noise
  function automatic in_item_t step_item();
    in_item_t it;
    it.mode     = MODE_STEP;
    it.x_start  = COORD_W'($urandom);
    it.y_start  = COORD_W'($urandom);
    it.x_end    = COORD_W'($urandom);
    it.y_end    = COORD_W'($urandom);
    it.edge_req = EDGE_W'($urandom);
    return it;
  endfunction

  task automatic predict_pixel(in_item_t it);
    res_item_t px;
    longint dx;
    longint dy;
    longint len;
    px = '0;
    if (it.mode == MODE_START) begin
      dx = longint'(it.x_end) - longint'(it.x_start);
      dy = longint'(it.y_end) - longint'(it.y_start);
      len = (dx < 0) ? -dx : dx;
      if (dy > len) len = dy;
      if (-dy > len) len = -dy;
      case (it.edge_req)
        EDGE_RED:    line_color = COLOR_RED;
        EDGE_YELLOW: line_color = COLOR_YELLOW;
        default:     line_color = COLOR_CYAN;
      endcase
      line_x_acc = longint'(it.x_start) << FRAC_BITS;
      line_y_acc = longint'(it.y_start) << FRAC_BITS;
      if (len == 0) begin
        line_x_inc  = 0;
        line_y_inc  = 0;
        pixels_left = 0;
        line_on     = 1'b0;
      end else begin
        line_x_inc  = dda_increment(dx, len);
        line_y_inc  = dda_increment(dy, len);
        pixels_left = len;
        line_on     = 1'b1;
      end
      px.last      = (len == 0);
      px.valid_res = 1'b1;
    end else if (!line_on || pixels_left == 0) begin
      line_on = 1'b0;
    end else begin
      line_x_acc  += line_x_inc;
      line_y_acc  += line_y_inc;
      pixels_left -= 1;
      if (pixels_left == 0) line_on = 1'b0;
      px.last      = (pixels_left == 0);
      px.valid_res = 1'b1;
    end
    if (px.valid_res) begin
      px.pixel_x = round_coord(line_x_acc);
      px.pixel_y = round_coord(line_y_acc);
      px.color   = line_color;
    end
    expected_pixels.push_back(px);
  endtask

  // push stays high after the transaction so back-to-back items need no gap
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (full);
    predict_pixel(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  task automatic test_idle_step();
    send_item(step_item());
    send_item(step_item());
  endtask

  task automatic test_zero_length();
    send_item(start_item(0, 0, 0, 0, EDGE_RED));
    send_item(start_item(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, EDGE_SPARE));
    send_item(step_item());
  endtask

  // full short line with a negative x slope, then one step past the end
  task automatic test_short_line();
    send_item(start_item(100, 200, 97, 205, EDGE_CYAN));
    repeat (6) send_item(step_item());
  endtask

  // accumulators landing exactly on .5 in both directions
  task automatic test_rounding_ties();
    send_item(start_item(0, 4, 4, 2, EDGE_RED));
    repeat (4) send_item(step_item());
    send_item(start_item(20, 0, 22, 1, EDGE_YELLOW));
    repeat (2) send_item(step_item());
  endtask

  // longest lines, each dropped by the next start, then a zero-length line and a step
  task automatic test_extremes();
    send_item(start_item(0, COORD_TOP, COORD_TOP, 0, EDGE_CYAN));
    repeat (2) send_item(step_item());
    send_item(start_item(COORD_TOP, 0, 0, COORD_TOP, EDGE_SPARE));
    send_item(step_item());
    send_item(start_item(7, 9, 7, 9, EDGE_YELLOW));
    send_item(step_item());
  endtask

  // results held back long enough for the block to stall its input
  task automatic test_backpressure();
    int unsigned saved_gap;
    wait_drained();
    saved_gap = send_gap_max;
    send_gap_max = 0;
    pop_hold_cycles = LONG_HOLD;
    send_item(start_item(50, 60, 90, 75, EDGE_YELLOW));
    repeat (30) send_item(step_item());
    wait_drained();
    send_gap_max = saved_gap;
  endtask

  task automatic test_random();
    int unsigned kind;
    int unsigned segment;
    int unsigned n_steps;
    int x0;
    int y0;
    int x1;
    int y1;
    int reach;
    int len;
    segment = 0;
    while (items_sent < RANDOM_END) begin
      if (items_sent / 100 != segment) begin
        segment = items_sent / 100;
        wait_drained();
        case (segment % 4)
          0: begin send_gap_max = 9; pop_gap_max = 9; end
          1: begin send_gap_max = 0; pop_gap_max = 0; end
          2: begin send_gap_max = 9; pop_gap_max = 0; end
          default: begin send_gap_max = 0; pop_gap_max = 9; end
        endcase
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_item(step_item());
      end else begin
        x0 = $urandom_range(0, COORD_TOP);
        y0 = $urandom_range(0, COORD_TOP);
        if (kind == 1) begin
          x1 = $urandom_range(0, COORD_TOP);
          y1 = $urandom_range(0, COORD_TOP);
        end else begin
          reach = $urandom_range(0, 24);
          x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
          y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
        end
        send_item(start_item(x0, y0, x1, y1, EDGE_W'($urandom_range(0, 3))));
        len = abs_diff(x0, x1);
        if (abs_diff(y0, y1) > len) len = abs_diff(y0, y1);
        if (kind == 1) begin
          n_steps = $urandom_range(0, 5);
        end else if ($urandom_range(0, 4) == 0) begin
          n_steps = $urandom_range(0, len);
        end else begin
          n_steps = len + $urandom_range(0, 2);
        end
        repeat (n_steps) send_item(step_item());
      end
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, res_data);
        mismatch_count++;
      end else begin
        next_pixel = expected_pixels.pop_front();
        check_field("pixel_x", 16'(next_pixel.pixel_x), 16'(res_data.pixel_x));
        check_field("pixel_y", 16'(next_pixel.pixel_y), 16'(res_data.pixel_y));
        check_field("color", 16'(next_pixel.color), 16'(res_data.color));
        check_field("last", 16'(next_pixel.last), 16'(res_data.last));
        check_field("valid_res", 16'(next_pixel.valid_res), 16'(res_data.valid_res));
      end
    end
  end

  // receiver side, one stall draw per transaction
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (pop_hold_cycles != 0) begin
        stall = pop_hold_cycles;
        pop_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, pop_gap_max);
      end
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_step();
    test_zero_length();
    test_short_line();
    test_rounding_ties();
    test_extremes();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dda_pkg.sv
src/dda_front.sv
src/dda_div.sv
src/dda_back.sv
src/dda_line_rasterizer.sv
tb/sv/testbench.sv
